// ===== rtl/srr_pkg.sv =====
package srr_pkg;

  localparam int SEQ_BITS = 8;
  localparam int MOD_BITS = 9;
  localparam int WORD_BITS = 64;

  localparam logic [MOD_BITS-1:0] MOD_RESET = 9'd8;
  localparam logic [MOD_BITS-1:0] MOD_MIN = 9'd2;
  localparam logic [MOD_BITS-1:0] MOD_MAX = 9'd256;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK = 1'b1;

  typedef struct packed {
    logic [SEQ_BITS-1:0]  seq_num;
    logic [WORD_BITS-1:0] payload_word;
    logic                 checksum_ok;
  } pkt_t;

  typedef struct packed {
    logic                 kind;
    logic [WORD_BITS-1:0] data_out;
    logic [SEQ_BITS-1:0]  ack_num;
    logic                 last;
  } res_t;

endpackage

// ===== rtl/srr_rem.sv =====
module srr_rem (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [srr_pkg::SEQ_BITS-1:0]  dividend,
  input  logic [srr_pkg::MOD_BITS-1:0]  modulus,
  output logic                          done,
  output logic [srr_pkg::MOD_BITS-1:0]  rem
);

  localparam int CW = $clog2(srr_pkg::SEQ_BITS);

  logic                         busy;
  logic [CW-1:0]                count;
  logic [srr_pkg::SEQ_BITS-1:0] dvd;
  logic [srr_pkg::MOD_BITS:0]   trial;
  logic [srr_pkg::MOD_BITS-1:0] rem_next;

  always_comb begin
    trial = {rem, dvd[srr_pkg::SEQ_BITS-1]};
    if (trial >= {1'b0, modulus}) begin
      trial = trial - {1'b0, modulus};
    end
    rem_next = trial[srr_pkg::MOD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CW'(srr_pkg::SEQ_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[srr_pkg::SEQ_BITS-2:0], 1'b0};
    end
  end

endmodule

// ===== rtl/srr_slot_mem.sv =====
module srr_slot_mem #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 64,
  parameter int AW = 2
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/selective_repeat_receiver.sv =====
// Selective-repeat ARQ receiver. Each packet transaction carries a sequence number, a payload
// word and an upstream checksum flag; a packet with a bad checksum is dropped and yields
// nothing. A good packet is buffered if it falls inside the window on an empty slot, then
// all contiguous buffered payloads at the window base are delivered in order, and finally one
// acknowledgement carrying the packet's own sequence number is sent with last set. For a good
// packet, two passes through the bit-serial remainder unit reduce the base and the sequence
// number modulo the sequence space, and each delivery reads the payload memory and then loads
// the output register, waiting while the output is stalled. No new packet is accepted until
// the acknowledgement is sent. The modulus register is written only while the block waits
// for a packet.
module selective_repeat_receiver #(
  parameter int WINDOW = 4,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pkt_valid,
  output logic                         pkt_ready,
  input  srr_pkg::pkt_t                pkt,
  output logic                         res_valid,
  input  logic                         res_ready,
  output srr_pkg::res_t                res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [srr_pkg::MOD_BITS-1:0] cfg_data
);

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIVB = 7'b0000010,
    S_DIVS = 7'b0000100,
    S_OFFS = 7'b0001000,
    S_RD   = 7'b0010000,
    S_DLV  = 7'b0100000,
    S_ACK  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [srr_pkg::MOD_BITS-1:0] seq_modulus;
  logic [srr_pkg::MOD_BITS-1:0] mod;
  logic [srr_pkg::SEQ_BITS-1:0] window_base;
  logic [srr_pkg::SEQ_BITS-1:0] base_r;
  logic [srr_pkg::SEQ_BITS-1:0] seq_r;
  logic [srr_pkg::SEQ_BITS-1:0] pkt_seq;
  logic [PAYLOAD_BITS-1:0]      pkt_payload;
  logic [WINDOW-1:0]            filled;
  logic [IW-1:0]                head;

  logic                         div_start;
  logic [srr_pkg::SEQ_BITS-1:0] div_dividend;
  logic                         div_done;
  logic [srr_pkg::MOD_BITS-1:0] div_rem;

  logic [srr_pkg::MOD_BITS:0]   off_sum;
  logic [srr_pkg::MOD_BITS-1:0] offset;
  logic [IW:0]                  phys_sum;
  logic [IW-1:0]                phys;
  logic                         store;
  logic [srr_pkg::MOD_BITS-1:0] base_inc;
  logic [srr_pkg::SEQ_BITS-1:0] base_next;
  logic [IW-1:0]                head_next;

  logic                         mem_re;
  logic [PAYLOAD_BITS-1:0]      mem_rdata;
  logic                         out_free;
  logic                         res_load;
  srr_pkg::res_t                res_next;

  always_comb begin
    if (seq_modulus < srr_pkg::MOD_MIN) begin
      mod = srr_pkg::MOD_MIN;
    end else if (seq_modulus > srr_pkg::MOD_MAX) begin
      mod = srr_pkg::MOD_MAX;
    end else begin
      mod = seq_modulus;
    end
  end

  assign pkt_ready = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  assign div_start = (pkt_valid && pkt_ready && pkt.checksum_ok) ||
                     (state == S_DIVB && div_done);
  assign div_dividend = (state == S_IDLE) ? window_base : pkt_seq;

  srr_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .modulus  (mod),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    off_sum = {2'b00, seq_r} + {1'b0, mod} - {2'b00, base_r};
    if (off_sum >= {1'b0, mod}) begin
      off_sum = off_sum - {1'b0, mod};
    end
    offset = off_sum[srr_pkg::MOD_BITS-1:0];
    phys_sum = {1'b0, head} + (IW + 1)'(offset[IW-1:0]);
    if (phys_sum >= (IW + 1)'(WINDOW)) begin
      phys_sum = phys_sum - (IW + 1)'(WINDOW);
    end
    phys = phys_sum[IW-1:0];
    store = (state == S_OFFS) && (offset < srr_pkg::MOD_BITS'(WINDOW)) && !filled[phys];
  end

  always_comb begin
    base_inc = {1'b0, base_r} + 1'b1;
    if (base_inc == mod) begin
      base_inc = '0;
    end
    base_next = base_inc[srr_pkg::SEQ_BITS-1:0];
    head_next = (head == IW'(WINDOW - 1)) ? '0 : head + 1'b1;
  end

  assign mem_re = (state == S_RD) && filled[head];

  srr_slot_mem #(
    .DEPTH (WINDOW),
    .WIDTH (PAYLOAD_BITS),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (store),
    .waddr (phys),
    .wdata (pkt_payload),
    .re    (mem_re),
    .raddr (head),
    .rdata (mem_rdata)
  );

  assign out_free = !res_valid || res_ready;

  always_comb begin
    res_load = 1'b0;
    res_next = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pkt_valid && pkt.checksum_ok) begin
          state_next = S_DIVB;
        end
      end
      S_DIVB: begin
        if (div_done) begin
          state_next = S_DIVS;
        end
      end
      S_DIVS: begin
        if (div_done) begin
          state_next = S_OFFS;
        end
      end
      S_OFFS: begin
        state_next = S_RD;
      end
      S_RD: begin
        state_next = filled[head] ? S_DLV : S_ACK;
      end
      S_DLV: begin
        if (out_free) begin
          res_load = 1'b1;
          res_next.kind = srr_pkg::KIND_DELIVER;
          res_next.data_out = srr_pkg::WORD_BITS'(mem_rdata);
          state_next = S_RD;
        end
      end
      S_ACK: begin
        if (out_free) begin
          res_load = 1'b1;
          res_next.kind = srr_pkg::KIND_ACK;
          res_next.ack_num = pkt_seq;
          res_next.last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seq_modulus <= srr_pkg::MOD_RESET;
      window_base <= '0;
      filled <= '0;
      head <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        seq_modulus <= cfg_data;
      end
      if (store) begin
        filled[phys] <= 1'b1;
      end
      if (state == S_DLV && out_free) begin
        filled[head] <= 1'b0;
        head <= head_next;
        window_base <= base_next;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_valid && pkt_ready) begin
      pkt_seq <= pkt.seq_num;
      pkt_payload <= pkt.payload_word[PAYLOAD_BITS-1:0];
    end
    if (state == S_DIVB && div_done) begin
      base_r <= div_rem[srr_pkg::SEQ_BITS-1:0];
    end
    if (state == S_DIVS && div_done) begin
      seq_r <= div_rem[srr_pkg::SEQ_BITS-1:0];
    end
    if (state == S_DLV && out_free) begin
      base_r <= base_next;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

`ifndef SYNTH
  a_head_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !filled[head])
    else $error("slot at the window base is filled while waiting for a packet");

  a_reduced_operands: assert property (@(posedge clk) disable iff (rst)
    (state == S_OFFS) |-> (({1'b0, base_r} < mod) && ({1'b0, seq_r} < mod)))
    else $error("base or sequence number not reduced below the modulus");

  a_delivery_not_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == srr_pkg::KIND_DELIVER) |-> !res.last)
    else $error("delivery transaction marked as last");
`endif

endmodule
